/* hdl/fgn_pkg.sv */
// shared constants, types and helper functions for the film grain noise adder
`default_nettype none

package fgn_pkg;

  // lcg and position hash constants
  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;
  localparam logic [31:0] HASH_X  = 32'd73856093;
  localparam logic [31:0] HASH_Y  = 32'd19349663;
  localparam logic [31:0] SALT_G  = 32'hDEADBEEF;
  localparam logic [31:0] SALT_B  = 32'hCAFEBABE;

  // reciprocal divide of a coordinate (up to 16 bits) by the grain size
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  // reciprocal divide of a magnitude below 2^14 by 127
  localparam int          DIV127_SHIFT = 21;
  localparam logic [14:0] DIV127_MUL   = 15'd16514;

  // total pipeline depth from input transfer to result strobe
  localparam int PIPE_LAT = 9;

  // config register indexes
  typedef enum logic [1:0] {
    CFG_FRAME_SEED  = 2'd0,
    CFG_GRAIN_SIZE  = 2'd1,
    CFG_COLOR_MODE  = 2'd2,
    CFG_NOISE_SCALE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

  // ceil(2^20 / size), a size of zero behaves as one
  function automatic logic [RECIP_W-1:0] grain_recip(input logic [3:0] gs);
    logic [RECIP_W-1:0] m;
    case (gs)
      4'd0:    m = 21'd1048576;
      4'd1:    m = 21'd1048576;
      4'd2:    m = 21'd524288;
      4'd3:    m = 21'd349526;
      4'd4:    m = 21'd262144;
      4'd5:    m = 21'd209716;
      4'd6:    m = 21'd174763;
      4'd7:    m = 21'd149797;
      4'd8:    m = 21'd131072;
      4'd9:    m = 21'd116509;
      4'd10:   m = 21'd104858;
      4'd11:   m = 21'd95326;
      4'd12:   m = 21'd87382;
      4'd13:   m = 21'd80660;
      4'd14:   m = 21'd74899;
      4'd15:   m = 21'd69906;
      default: m = 21'd1048576;
    endcase
    return m;
  endfunction

  // one lcg step modulo 2^32
  function automatic logic [31:0] lcg_step(input logic [31:0] s);
    logic [31:0] p;
    p = 32'(s * LCG_MUL);
    return p + LCG_ADD;
  endfunction

endpackage

`default_nettype wire

/* hdl/fgn_chan.sv */
// one color channel: lcg value to noise, scale, divide by 127, add and saturate
`default_nettype none

module fgn_chan (
  input  wire logic        clk,
  input  wire logic [23:0] frac,
  input  wire logic [7:0]  color,
  input  wire logic [6:0]  scale,
  output logic      [7:0]  result
);

  logic [31:0]        frac255;
  logic signed [8:0]  noise;
  logic signed [16:0] prod_full;
  logic signed [15:0] prod_nxt, prod_r;
  logic [7:0]         col_a_r, col_b_r;
  logic [15:0]        mag_full;
  logic [13:0]        mag;
  logic [28:0]        quot_full;
  logic [6:0]         quot_nxt, quot_r;
  logic               neg_r;
  logic signed [9:0]  delta;
  logic signed [9:0]  sum;
  logic [7:0]         result_nxt, result_r;

  // noise in -127..127 from the low 24 bits, then times the scale
  always_comb begin
    frac255   = {frac, 8'd0} - {8'd0, frac};
    noise     = $signed({1'b0, frac255[31:24]}) - 9'sd127;
    prod_full = noise * $signed({1'b0, scale});
    prod_nxt  = prod_full[15:0];
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    col_a_r <= color;
  end

  // magnitude divided by 127 through a reciprocal multiply
  always_comb begin
    mag_full  = prod_r[15] ? 16'(-prod_r) : 16'(prod_r);
    mag       = mag_full[13:0];
    quot_full = 29'(mag * fgn_pkg::DIV127_MUL);
    quot_nxt  = quot_full[fgn_pkg::DIV127_SHIFT +: 7];
  end

  always_ff @(posedge clk) begin
    quot_r  <= quot_nxt;
    neg_r   <= prod_r[15];
    col_b_r <= col_a_r;
  end

  // restore sign, add and clamp to byte range
  always_comb begin
    delta = neg_r ? -$signed({3'd0, quot_r}) : $signed({3'd0, quot_r});
    sum   = $signed({2'd0, col_b_r}) + delta;
    if (sum < 10'sd0) begin
      result_nxt = 8'd0;
    end else if (sum > 10'sd255) begin
      result_nxt = 8'd255;
    end else begin
      result_nxt = sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign result = result_r;

endmodule

`default_nettype wire

/* hdl/film_grain_noise_adder.sv */
// top level of the film grain noise adder: config registers, hash and lcg pipeline
`default_nettype none

// Adds hashed, blocky film grain to one RGBA pixel per clock. A pixel is
// transferred on any clock edge with start high and busy low; busy is always
// low, so a new pixel may come every cycle. Its result is on the out_ ports
// for exactly one cycle with out_valid high, once the pixel has passed all
// stages; the receiver must take it then. The 9 stages are: grain block
// divide, position hash, seed mix, first lcg step, salt adds, channel lcg
// steps, noise times scale, divide by 127, add and saturate. Config writes are
// always ready and are meant to be done while no pixel is in flight.
module film_grain_noise_adder #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // pixel input
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [COORD_BITS-1:0] in_pos_x,
  input  wire logic [COORD_BITS-1:0] in_pos_y,
  input  wire logic [7:0]            in_red,
  input  wire logic [7:0]            in_green,
  input  wire logic [7:0]            in_blue,
  input  wire logic [7:0]            in_alpha,
  // pixel result
  output logic                       out_valid,
  output logic [7:0]                 out_red,
  output logic [7:0]                 out_green,
  output logic [7:0]                 out_blue,
  output logic [7:0]                 out_alpha,
  // config write
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [31:0]           cfg_data
);

  localparam int LAT     = fgn_pkg::PIPE_LAT;
  localparam int PRE_LAT = 6;
  localparam int POST    = LAT - PRE_LAT;
  localparam int PROD_W  = COORD_BITS + fgn_pkg::RECIP_W;

  // config registers
  logic [31:0] frame_seed_r, frame_seed_nxt;
  logic [3:0]  grain_size_r, grain_size_nxt;
  logic        color_mode_r, color_mode_nxt;
  logic [6:0]  noise_scale_r, noise_scale_nxt;
  logic        cfg_xfer;

  // pipeline
  logic               in_xfer;
  logic [LAT-1:0]     vld_r, vld_nxt;
  fgn_pkg::pix_t      pix_in;
  fgn_pkg::pix_t      pix_r [PRE_LAT];
  logic [7:0]         alpha_r [POST];
  logic [fgn_pkg::RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  px_r, py_r, px_nxt, py_nxt;
  logic [COORD_BITS-1:0] bx, by;
  logic [31:0]        hx_r, hy_r, hx_nxt, hy_nxt;
  logic [31:0]        seed_r, seed_nxt;
  logic [31:0]        s1_r, s1_nxt;
  logic [31:0]        sa_r, sg_r, sb_r;
  logic [31:0]        vr_r, vg_r, vb_r, vr_nxt, vg_nxt, vb_nxt;
  logic [7:0]         res_red, res_green, res_blue;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign in_xfer   = start && !busy;

  // config register write decode
  always_comb begin
    frame_seed_nxt  = frame_seed_r;
    grain_size_nxt  = grain_size_r;
    color_mode_nxt  = color_mode_r;
    noise_scale_nxt = noise_scale_r;
    if (cfg_xfer) begin
      case (fgn_pkg::cfg_idx_t'(cfg_index))
        fgn_pkg::CFG_FRAME_SEED:  frame_seed_nxt  = cfg_data;
        fgn_pkg::CFG_GRAIN_SIZE:  grain_size_nxt  = cfg_data[3:0];
        fgn_pkg::CFG_COLOR_MODE:  color_mode_nxt  = cfg_data[0];
        fgn_pkg::CFG_NOISE_SCALE: noise_scale_nxt = cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_seed_r  <= 32'd9999;
      grain_size_r  <= 4'd1;
      color_mode_r  <= 1'b0;
      noise_scale_r <= 7'd38;
    end else begin
      frame_seed_r  <= frame_seed_nxt;
      grain_size_r  <= grain_size_nxt;
      color_mode_r  <= color_mode_nxt;
      noise_scale_r <= noise_scale_nxt;
    end
  end

  // valid bits travel with the data
  assign vld_nxt = {vld_r[LAT-2:0], in_xfer};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // pixel carry line
  assign pix_in = '{red: in_red, green: in_green, blue: in_blue, alpha: in_alpha};

  always_ff @(posedge clk) begin
    pix_r[0] <= pix_in;
    for (int i = 1; i < PRE_LAT; i++) begin
      pix_r[i] <= pix_r[i-1];
    end
    alpha_r[0] <= pix_r[PRE_LAT-1].alpha;
    for (int i = 1; i < POST; i++) begin
      alpha_r[i] <= alpha_r[i-1];
    end
  end

  // stage 1: coordinate times reciprocal of grain size
  always_comb begin
    recip  = fgn_pkg::grain_recip(grain_size_r);
    px_nxt = PROD_W'(in_pos_x * recip);
    py_nxt = PROD_W'(in_pos_y * recip);
  end

  // stage 2: block index times hash constants
  always_comb begin
    bx     = px_r[fgn_pkg::RECIP_SHIFT +: COORD_BITS];
    by     = py_r[fgn_pkg::RECIP_SHIFT +: COORD_BITS];
    hx_nxt = 32'(bx * fgn_pkg::HASH_X);
    hy_nxt = 32'(by * fgn_pkg::HASH_Y);
  end

  // stage 3 and 4: seed mix, first lcg step
  assign seed_nxt = frame_seed_r ^ hx_r ^ hy_r;
  assign s1_nxt   = fgn_pkg::lcg_step(seed_r);

  // stage 6: channel lcg steps, or the first value shared in mono mode
  always_comb begin
    if (color_mode_r) begin
      vr_nxt = fgn_pkg::lcg_step(sa_r);
      vg_nxt = fgn_pkg::lcg_step(sg_r);
      vb_nxt = fgn_pkg::lcg_step(sb_r);
    end else begin
      vr_nxt = sa_r;
      vg_nxt = sa_r;
      vb_nxt = sa_r;
    end
  end

  always_ff @(posedge clk) begin
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    hx_r   <= hx_nxt;
    hy_r   <= hy_nxt;
    seed_r <= seed_nxt;
    s1_r   <= s1_nxt;
    sa_r   <= s1_r;
    sg_r   <= s1_r + fgn_pkg::SALT_G;
    sb_r   <= s1_r + fgn_pkg::SALT_B;
    vr_r   <= vr_nxt;
    vg_r   <= vg_nxt;
    vb_r   <= vb_nxt;
  end

  // stages 7 to 9 per channel
  fgn_chan u_chan_red (
    .clk    (clk),
    .frac   (vr_r[23:0]),
    .color  (pix_r[PRE_LAT-1].red),
    .scale  (noise_scale_r),
    .result (res_red)
  );

  fgn_chan u_chan_green (
    .clk    (clk),
    .frac   (vg_r[23:0]),
    .color  (pix_r[PRE_LAT-1].green),
    .scale  (noise_scale_r),
    .result (res_green)
  );

  fgn_chan u_chan_blue (
    .clk    (clk),
    .frac   (vb_r[23:0]),
    .color  (pix_r[PRE_LAT-1].blue),
    .scale  (noise_scale_r),
    .result (res_blue)
  );

  assign out_valid = vld_r[LAT-1];
  assign out_red   = res_red;
  assign out_green = res_green;
  assign out_blue  = res_blue;
  assign out_alpha = alpha_r[POST-1];

  // a result strobe always traces back to a transfer through every stage
  a_strobe_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vld_r[0], LAT - 1))
    else $error("result strobe without a matching transfer");

  // alpha leaves exactly as it came in
  a_alpha_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_alpha == $past(in_alpha, LAT))
    else $error("alpha changed in flight");

  // mono mode feeds one noise value to all three channels
  a_mono_shared: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[PRE_LAT-1] && !$past(color_mode_r)) |-> (vr_r == vg_r && vg_r == vb_r))
    else $error("mono mode channel noise differs");

endmodule

`default_nettype wire
